[rtl/core/swt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and constants of the shell word tokenizer.
// Used by swt_parse and shell_word_tokenizer_top; depends on nothing.
package swt_pkg;

  localparam int unsigned MAX_TOKENS_DEF     = 64;
  localparam int unsigned MAX_LINE_BYTES_DEF = 1024;

  localparam int unsigned RES_SLOTS     = 4;
  localparam int unsigned RES_CNT_W     = 3;
  localparam int unsigned SLOT_IDX_W    = 2;
  localparam int unsigned TOKEN_COUNT_W = 7;
  localparam int unsigned IN_TDATA_W    = 8;
  localparam int unsigned OUT_TDATA_W   = 24;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;

  typedef enum logic [2:0] {
    KIND_TOK_BYTE  = 3'd0,
    KIND_TOK_END   = 3'd1,
    KIND_TOK_DROP  = 3'd2,
    KIND_NAME_BYTE = 3'd3,
    KIND_NAME_END  = 3'd4,
    KIND_LINE_DONE = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_NONE     = 2'd0,
    PH_AFTER_GT = 2'd1,
    PH_BLANKS   = 2'd2,
    PH_NAME     = 2'd3
  } redir_phase_t;

  typedef enum logic [1:0] {
    PREV_NONE   = 2'd0,
    PREV_STDOUT = 2'd1,
    PREV_STDERR = 2'd2
  } prev_code_t;

  typedef struct packed {
    logic                     overflow;
    logic [TOKEN_COUNT_W-1:0] token_count;
    logic                     append;
    logic                     to_stderr;
    logic [7:0]               out_byte;
    kind_t                    kind;
  } res_t;

  typedef res_t [RES_SLOTS-1:0] res_set_t;

  function automatic res_t mk_res(kind_t kind, logic [7:0] data, logic err, logic app,
                                  logic [TOKEN_COUNT_W-1:0] count, logic ovf);
    res_t r;
    r.kind        = kind;
    r.out_byte    = data;
    r.to_stderr   = err;
    r.append      = app;
    r.token_count = count;
    r.overflow    = ovf;
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage
`default_nettype wire

[rtl/core/swt_parse.sv]
`timescale 1ns / 1ps
`default_nettype none
// Parser state of the tokenizer and the single-pass logic that turns one
// item into up to three results. Depends on swt_pkg.
module swt_parse import swt_pkg::*; #(
  parameter int unsigned MAX_TOKENS     = MAX_TOKENS_DEF,
  parameter int unsigned MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  wire logic [7:0]           char_byte,
  input  wire logic                 line_end,
  output res_set_t                  res,
  output logic [RES_CNT_W-1:0]      res_n
);

  localparam int unsigned LEN_W = $clog2(MAX_LINE_BYTES);
  localparam int unsigned CNT_W = $clog2(MAX_TOKENS + 1);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_TOKENS);

  logic             sq_r, sq_nxt;
  logic             dq_r, dq_nxt;
  logic             bs_r, bs_nxt;
  redir_phase_t     ph_r, ph_nxt;
  logic             rerr_r, rerr_nxt;
  logic             rapp_r, rapp_nxt;
  logic [LEN_W-1:0] tlen_r, tlen_nxt;
  logic [7:0]       tfirst_r, tfirst_nxt;
  prev_code_t       prev_r, prev_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic             ovf_r, ovf_nxt;

  logic       pa_en;
  logic [7:0] pa_byte;
  logic       act_bs, act_sq, act_dq, act_add, act_end, act_redir;
  logic       redir_done;

  // Decode the action for the item from the current state.
  always_comb begin
    pa_en     = 1'b0;
    pa_byte   = CH_BSLASH;
    act_bs    = 1'b0;
    act_sq    = 1'b0;
    act_dq    = 1'b0;
    act_add   = 1'b0;
    act_end   = 1'b0;
    act_redir = 1'b0;
    if (ph_r == PH_NONE) begin
      if (line_end) begin
        pa_en   = bs_r;
        act_end = 1'b1;
      end else begin
        if (bs_r && (!dq_r || char_byte == CH_DQUOTE || char_byte == CH_BSLASH)) begin
          pa_en   = 1'b1;
          pa_byte = char_byte;
        end else begin
          pa_en = bs_r;
          if (char_byte == CH_BSLASH && !sq_r) begin
            act_bs = 1'b1;
          end else if (char_byte == CH_SQUOTE && !dq_r) begin
            act_sq = 1'b1;
          end else if (char_byte == CH_DQUOTE && !sq_r) begin
            act_dq = 1'b1;
          end else if (!sq_r && !dq_r && is_blank(char_byte)) begin
            act_end = 1'b1;
          end else if (!sq_r && !dq_r && char_byte == CH_GT) begin
            act_end   = 1'b1;
            act_redir = 1'b1;
          end else begin
            act_add = 1'b1;
          end
        end
      end
    end
  end

  // Apply the actions in order, collecting results as they arise.
  always_comb begin
    sq_nxt     = sq_r ^ act_sq;
    dq_nxt     = dq_r ^ act_dq;
    bs_nxt     = (ph_r == PH_NONE && !line_end) ? act_bs : bs_r;
    ph_nxt     = ph_r;
    rerr_nxt   = rerr_r;
    rapp_nxt   = rapp_r;
    tlen_nxt   = tlen_r;
    tfirst_nxt = tfirst_r;
    prev_nxt   = prev_r;
    seen_nxt   = seen_r;
    ovf_nxt    = ovf_r;
    res        = '0;
    res_n      = '0;
    redir_done = 1'b0;

    if (pa_en && tlen_nxt < LEN_LIMIT) begin
      if (tlen_nxt == '0) begin
        tfirst_nxt = pa_byte;
      end
      tlen_nxt = tlen_nxt + 1'b1;
      res[res_n[SLOT_IDX_W-1:0]] = mk_res(KIND_TOK_BYTE, pa_byte, 1'b0, 1'b0,
                                          TOKEN_COUNT_W'(seen_nxt), ovf_nxt);
      res_n = res_n + 1'b1;
    end

    if (act_add && tlen_nxt < LEN_LIMIT) begin
      if (tlen_nxt == '0) begin
        tfirst_nxt = char_byte;
      end
      tlen_nxt = tlen_nxt + 1'b1;
      res[res_n[SLOT_IDX_W-1:0]] = mk_res(KIND_TOK_BYTE, char_byte, 1'b0, 1'b0,
                                          TOKEN_COUNT_W'(seen_nxt), ovf_nxt);
      res_n = res_n + 1'b1;
    end

    if (act_end && tlen_nxt != '0) begin
      if (seen_nxt < CNT_LIMIT) begin
        seen_nxt = seen_nxt + 1'b1;
        prev_nxt = PREV_NONE;
        if (tlen_nxt == LEN_W'(1) && tfirst_nxt == CH_ONE) begin
          prev_nxt = PREV_STDOUT;
        end
        if (tlen_nxt == LEN_W'(1) && tfirst_nxt == CH_TWO) begin
          prev_nxt = PREV_STDERR;
        end
      end else begin
        ovf_nxt  = 1'b1;
        prev_nxt = PREV_NONE;
      end
      tlen_nxt = '0;
      res[res_n[SLOT_IDX_W-1:0]] = mk_res(KIND_TOK_END, 8'h00, 1'b0, 1'b0,
                                          TOKEN_COUNT_W'(seen_nxt), ovf_nxt);
      res_n = res_n + 1'b1;
    end

    if (act_redir) begin
      rerr_nxt = 1'b0;
      if (prev_nxt != PREV_NONE && seen_nxt != '0) begin
        rerr_nxt = (prev_nxt == PREV_STDERR);
        seen_nxt = seen_nxt - 1'b1;
        res[res_n[SLOT_IDX_W-1:0]] = mk_res(KIND_TOK_DROP, 8'h00, 1'b0, 1'b0,
                                            TOKEN_COUNT_W'(seen_nxt), ovf_nxt);
        res_n = res_n + 1'b1;
      end
      prev_nxt = PREV_NONE;
      rapp_nxt = 1'b0;
      ph_nxt   = PH_AFTER_GT;
      tlen_nxt = '0;
    end

    if (ph_r != PH_NONE && !line_end) begin
      if (ph_nxt == PH_AFTER_GT) begin
        ph_nxt = PH_BLANKS;
        if (char_byte == CH_GT) begin
          rapp_nxt   = 1'b1;
          redir_done = 1'b1;
        end else begin
          rapp_nxt = 1'b0;
        end
      end
      if (!redir_done) begin
        if (ph_nxt == PH_BLANKS) begin
          if (!is_blank(char_byte)) begin
            ph_nxt = PH_NAME;
            if (tlen_nxt < LEN_LIMIT) begin
              tlen_nxt = tlen_nxt + 1'b1;
              res[res_n[SLOT_IDX_W-1:0]] = mk_res(KIND_NAME_BYTE, char_byte, 1'b0, 1'b0,
                                                  TOKEN_COUNT_W'(seen_nxt), ovf_nxt);
              res_n = res_n + 1'b1;
            end
          end
        end else if (is_blank(char_byte)) begin
          res[res_n[SLOT_IDX_W-1:0]] = mk_res(KIND_NAME_END, 8'h00, rerr_nxt, rapp_nxt,
                                              TOKEN_COUNT_W'(seen_nxt), ovf_nxt);
          res_n    = res_n + 1'b1;
          ph_nxt   = PH_NONE;
          tlen_nxt = '0;
        end else if (tlen_nxt < LEN_LIMIT) begin
          tlen_nxt = tlen_nxt + 1'b1;
          res[res_n[SLOT_IDX_W-1:0]] = mk_res(KIND_NAME_BYTE, char_byte, 1'b0, 1'b0,
                                              TOKEN_COUNT_W'(seen_nxt), ovf_nxt);
          res_n = res_n + 1'b1;
        end
      end
    end

    if (line_end) begin
      if (ph_r != PH_NONE) begin
        res[res_n[SLOT_IDX_W-1:0]] = mk_res(KIND_NAME_END, 8'h00, rerr_nxt, rapp_nxt,
                                            TOKEN_COUNT_W'(seen_nxt), ovf_nxt);
        res_n = res_n + 1'b1;
      end
      res[res_n[SLOT_IDX_W-1:0]] = mk_res(KIND_LINE_DONE, 8'h00, 1'b0, 1'b0,
                                          TOKEN_COUNT_W'(seen_nxt), ovf_nxt);
      res_n      = res_n + 1'b1;
      sq_nxt     = 1'b0;
      dq_nxt     = 1'b0;
      bs_nxt     = 1'b0;
      ph_nxt     = PH_NONE;
      rerr_nxt   = 1'b0;
      rapp_nxt   = 1'b0;
      tlen_nxt   = '0;
      tfirst_nxt = 8'h00;
      prev_nxt   = PREV_NONE;
      seen_nxt   = '0;
      ovf_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r     <= 1'b0;
      dq_r     <= 1'b0;
      bs_r     <= 1'b0;
      ph_r     <= PH_NONE;
      rerr_r   <= 1'b0;
      rapp_r   <= 1'b0;
      tlen_r   <= '0;
      tfirst_r <= 8'h00;
      prev_r   <= PREV_NONE;
      seen_r   <= '0;
      ovf_r    <= 1'b0;
    end else if (step_en) begin
      sq_r     <= sq_nxt;
      dq_r     <= dq_nxt;
      bs_r     <= bs_nxt;
      ph_r     <= ph_nxt;
      rerr_r   <= rerr_nxt;
      rapp_r   <= rapp_nxt;
      tlen_r   <= tlen_nxt;
      tfirst_r <= tfirst_nxt;
      prev_r   <= prev_nxt;
      seen_r   <= seen_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/shell_word_tokenizer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// The first result of an item is presented from the result buffer, loaded from the input register once it is free.
// One item per cycle while each item gives at most one result and out_tready is high;
// an item with several results holds the four-entry result buffer until all are taken.
// Reset (rst_n low, synchronous) clears the parser state and empties the
// input register and the result buffer. Depends on swt_pkg and swt_parse.
module shell_word_tokenizer_top import swt_pkg::*; #(
  parameter int unsigned MAX_TOKENS     = MAX_TOKENS_DEF,
  parameter int unsigned MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_byte
  input  wire logic                   in_tlast,   // line_end
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [2:0] kind, [10:3] out_byte, [11] to_stderr, [12] append,
  // [19:13] token_count, [20] overflow, [23:21] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast   // last
);

  logic                  inv_r;
  logic [7:0]            in_byte_r;
  logic                  in_le_r;
  logic                  buf_free;
  logic                  advance;
  res_set_t              step_res;
  logic [RES_CNT_W-1:0]  step_n;
  res_set_t              buf_r;
  logic [RES_CNT_W-1:0]  rem_r;
  logic [SLOT_IDX_W-1:0] rd_r;
  res_t                  head;

  assign buf_free  = (rem_r == '0) || (rem_r == RES_CNT_W'(1) && out_tready);
  assign advance   = inv_r && buf_free;
  assign in_tready = !inv_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      inv_r <= 1'b1;
    end else if (advance) begin
      inv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata[7:0];
      in_le_r   <= in_tlast;
    end
  end

  swt_parse #(
    .MAX_TOKENS     (MAX_TOKENS),
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .char_byte (in_byte_r),
    .line_end  (in_le_r),
    .res       (step_res),
    .res_n     (step_n)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      rd_r  <= '0;
    end else if (advance) begin
      rem_r <= step_n;
      rd_r  <= '0;
    end else if (out_tvalid && out_tready) begin
      rem_r <= rem_r - 1'b1;
      rd_r  <= rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      buf_r <= step_res;
    end
  end

  assign head       = buf_r[rd_r];
  assign out_tvalid = (rem_r != '0);
  assign out_tlast  = (rem_r == RES_CNT_W'(1));
  assign out_tdata  = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, head};

endmodule
`default_nettype wire
